/* sv/rht_pkg.sv */
package rht_pkg;

   // Default table size and the limit on reported releases of one clear-all.
   localparam int SLOT_COUNT_DEF = 64;
   localparam int RESULT_LIMIT   = 64;
   localparam int REP_W          = $clog2(RESULT_LIMIT + 1);

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Operation codes.
   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_GET   = 3'd2;
   localparam logic [2:0] OP_PUT   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   // Result status codes.
   localparam logic [1:0] STS_OK   = 2'd0;
   localparam logic [1:0] STS_FULL = 2'd1;
   localparam logic [1:0] STS_BAD  = 2'd2;
   localparam logic [1:0] STS_SAT  = 2'd3;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_ERR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FLUSH
   } rht_state_type;

   // Request word, last field (opcode) in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [3:0]  access_mode;
      logic [31:0] object_handle;
      logic [5:0]  slot;
      logic [2:0]  opcode;
   } rht_req_type;

   // Response word, last field (status) in the lowest bits.
   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] released_handle;
      logic [15:0] count_out;
      logic [3:0]  mode_out;
      logic [31:0] handle_out;
      logic [5:0]  slot_out;
      logic [1:0]  status;
   } rht_rsp_type;

   // One slot entry as read from the table.
   typedef struct packed {
      logic [31:0] hdl;
      logic [3:0]  mode;
      logic [15:0] cnt;
   } rht_entry_type;

   // Write command for the table.
   typedef struct packed {
      logic          hdl_we;
      logic          mode_we;
      logic          cnt_we;
      rht_entry_type data;
   } rht_wr_type;

endpackage

/* sv/rht_slot_mem.sv */
module rht_slot_mem #(
   parameter int SLOT_COUNT = rht_pkg::SLOT_COUNT_DEF,
   parameter int IDX_W      = $clog2(SLOT_COUNT)
) (
   input  logic                   clock,
   input  rht_pkg::rht_wr_type    wr,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output rht_pkg::rht_entry_type rd_data
);

   // Three narrow arrays so that each field has its own write enable.
   logic [31:0] hdl_mem  [SLOT_COUNT];
   logic [3:0]  mode_mem [SLOT_COUNT];
   logic [15:0] cnt_mem  [SLOT_COUNT];

   rht_pkg::rht_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.hdl_we) begin
         hdl_mem[wr_addr] <= wr.data.hdl;
      end
      if (wr.mode_we) begin
         mode_mem[wr_addr] <= wr.data.mode;
      end
      if (wr.cnt_we) begin
         cnt_mem[wr_addr] <= wr.data.cnt;
      end
   end

   // Read data is held until the next read so a stalled consumer sees it stable.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff.hdl  <= hdl_mem[rd_addr];
         rd_ff.mode <= mode_mem[rd_addr];
         rd_ff.cnt  <= cnt_mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* sv/refcounted_handle_table_core.sv */
// Free, get, put and rejected requests: the slot is read as the word is taken, the execute or
// error state then loads the result register, and no new word is taken before that. Alloc
// walks the table from slot 0 with a read state and a check state per slot, as the table
// has a single read port, and stops at the first free slot or after the last one. Clear-all
// walks every slot alike, waiting while the response side stalls. Reset is synchronous and
// active high; afterwards a pass zeroes every handle and no request word is taken until it ends.
module refcounted_handle_table_core #(
   parameter int SLOT_COUNT = rht_pkg::SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], slot[8:3], object_handle[40:9], access_mode[44:41], zero pad[47:45]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], slot_out[7:2], handle_out[39:8], mode_out[43:40], count_out[59:44],
   // released_handle[91:60], zero pad[95:92]
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   // Common width for moving between the 6-bit slot field and a table index.
   localparam int EXT_W = (IDX_W > 6) ? IDX_W : 6;

   rht_pkg::rht_state_type state_ff, state_in;

   // Captured request.
   logic [2:0]             op_ff, op_in;
   logic [5:0]             slot_ff, slot_in;
   logic [31:0]            hnd_ff, hnd_in;
   logic [3:0]             mode_ff, mode_in;

   // Walk index shared by the clearing pass, the alloc search and clear-all.
   logic [IDX_W-1:0]       idx_ff, idx_in;

   // Clear-all keeps one found release back so that the final one can carry last.
   logic [rht_pkg::REP_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic [5:0]             pend_slot_ff, pend_slot_in;
   logic [31:0]            pend_hdl_ff, pend_hdl_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   rht_pkg::rht_rsp_type   rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   rht_pkg::rht_req_type   req;
   rht_pkg::rht_entry_type rd;
   rht_pkg::rht_wr_type    mem_wr;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   logic                   req_fire;
   logic                   out_free;
   logic                   emit;
   logic                   hit;
   logic                   idx_last;
   logic                   rep_full;
   logic                   clr_need_emit;
   logic                   clr_stall;
   logic                   req_in_range;
   logic [EXT_W-1:0]       req_slot_ext;
   logic [EXT_W-1:0]       slot_ext;
   logic [EXT_W-1:0]       idx_ext;
   logic [IDX_W-1:0]       slot_addr;
   logic [15:0]            cnt_dec;
   logic [15:0]            cnt_inc;

   assign req = rht_pkg::rht_req_type'(req_tdata);

   // The table itself: handle, mode and count arrays with one read port.
   rht_slot_mem #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd)
   );

   assign req_tready = (state_ff == rht_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // A new result may be loaded when the output register is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_slot_ext = EXT_W'(req.slot);
   assign req_in_range = (32'(req.slot) < 32'(SLOT_COUNT));
   assign slot_ext     = EXT_W'(slot_ff);
   assign slot_addr    = slot_ext[IDX_W-1:0];
   assign idx_ext      = EXT_W'(idx_ff);

   // A slot is open when its handle is nonzero.
   assign hit      = (rd.hdl != 32'd0);
   assign idx_last = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign rep_full = (rep_cnt_ff == rht_pkg::REP_W'(rht_pkg::RESULT_LIMIT));

   // During clear-all, finding another open slot pushes the held release out.
   assign clr_need_emit = hit && !rep_full && (rep_cnt_ff != '0);
   assign clr_stall     = clr_need_emit && !out_free;

   // The count of an open slot is never zero, but the decrement still floors at zero.
   assign cnt_dec = (rd.cnt == 16'd0) ? 16'd0 : rd.cnt - 16'd1;
   assign cnt_inc = rd.cnt + 16'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rht_pkg::S_INIT: begin
            if (idx_last) begin
               state_in = rht_pkg::S_IDLE;
            end
         end
         rht_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (req.opcode)
                  rht_pkg::OP_ALLOC: begin
                     state_in = (req.object_handle == 32'd0) ? rht_pkg::S_ERR
                                                             : rht_pkg::S_SCAN_RD;
                  end
                  rht_pkg::OP_FREE, rht_pkg::OP_GET, rht_pkg::OP_PUT: begin
                     state_in = req_in_range ? rht_pkg::S_EXEC : rht_pkg::S_ERR;
                  end
                  rht_pkg::OP_CLEAR: begin
                     state_in = rht_pkg::S_SCAN_RD;
                  end
                  default: begin
                     state_in = rht_pkg::S_ERR;
                  end
               endcase
            end
         end
         rht_pkg::S_EXEC, rht_pkg::S_ERR, rht_pkg::S_FLUSH: begin
            if (out_free) begin
               state_in = rht_pkg::S_IDLE;
            end
         end
         rht_pkg::S_SCAN_RD: begin
            state_in = rht_pkg::S_SCAN_CHK;
         end
         rht_pkg::S_SCAN_CHK: begin
            if (op_ff == rht_pkg::OP_ALLOC) begin
               if (hit && !idx_last) begin
                  state_in = rht_pkg::S_SCAN_RD;
               end else if (out_free) begin
                  state_in = rht_pkg::S_IDLE;
               end
            end else if (!clr_stall) begin
               state_in = idx_last ? rht_pkg::S_FLUSH : rht_pkg::S_SCAN_RD;
            end
         end
         default: begin
            state_in = rht_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, table access and result formation.
   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      hnd_in       = hnd_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      rep_cnt_in   = rep_cnt_ff;
      pend_slot_in = pend_slot_ff;
      pend_hdl_in  = pend_hdl_ff;
      mem_wr       = '0;
      wr_addr      = idx_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      emit         = 1'b0;
      rsp_data_in  = '0;
      rsp_last_in  = 1'b1;

      unique case (state_ff)
         rht_pkg::S_INIT: begin
            // Clearing pass: every handle to zero, one slot per cycle.
            mem_wr.hdl_we = 1'b1;
            idx_in        = IDX_W'(idx_ff + 1'b1);
         end
         rht_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in        = req.opcode;
               slot_in      = req.slot;
               hnd_in       = req.object_handle;
               mode_in      = req.access_mode;
               idx_in       = '0;
               rep_cnt_in   = '0;
               pend_slot_in = '0;
               pend_hdl_in  = '0;
               // Read the addressed slot right away; out-of-range reads are ignored later.
               rd_en        = 1'b1;
               rd_addr      = req_slot_ext[IDX_W-1:0];
            end
         end
         rht_pkg::S_EXEC: begin
            wr_addr              = slot_addr;
            rsp_data_in.slot_out = slot_ff;
            if (out_free) begin
               emit = 1'b1;
               if (!hit) begin
                  rsp_data_in.status = rht_pkg::STS_BAD;
               end else if (op_ff == rht_pkg::OP_GET) begin
                  rsp_data_in.handle_out = rd.hdl;
                  rsp_data_in.mode_out   = rd.mode;
                  if (rd.cnt == rht_pkg::COUNT_MAX) begin
                     rsp_data_in.status    = rht_pkg::STS_SAT;
                     rsp_data_in.count_out = rd.cnt;
                  end else begin
                     mem_wr.cnt_we         = 1'b1;
                     mem_wr.data.cnt       = cnt_inc;
                     rsp_data_in.count_out = cnt_inc;
                  end
               end else begin
                  // Free and put drop one reference; the last one releases the slot.
                  mem_wr.cnt_we         = 1'b1;
                  mem_wr.data.cnt       = cnt_dec;
                  rsp_data_in.count_out = cnt_dec;
                  if (cnt_dec == 16'd0) begin
                     mem_wr.hdl_we               = 1'b1;
                     rsp_data_in.released_handle = rd.hdl;
                  end
               end
            end
         end
         rht_pkg::S_ERR: begin
            emit               = out_free;
            rsp_data_in.status = rht_pkg::STS_BAD;
            // A rejected alloc reports slot zero; everything else echoes the slot.
            rsp_data_in.slot_out = (op_ff == rht_pkg::OP_ALLOC) ? 6'd0 : slot_ff;
         end
         rht_pkg::S_SCAN_RD: begin
            rd_en = 1'b1;
         end
         rht_pkg::S_SCAN_CHK: begin
            if (op_ff == rht_pkg::OP_ALLOC) begin
               if (!hit) begin
                  if (out_free) begin
                     emit                   = 1'b1;
                     mem_wr.hdl_we          = 1'b1;
                     mem_wr.mode_we         = 1'b1;
                     mem_wr.cnt_we          = 1'b1;
                     mem_wr.data.hdl        = hnd_ff;
                     mem_wr.data.mode       = mode_ff;
                     mem_wr.data.cnt        = 16'd1;
                     rsp_data_in.slot_out   = idx_ext[5:0];
                     rsp_data_in.handle_out = hnd_ff;
                     rsp_data_in.mode_out   = mode_ff;
                     rsp_data_in.count_out  = 16'd1;
                  end
               end else if (idx_last) begin
                  emit               = out_free;
                  rsp_data_in.status = rht_pkg::STS_FULL;
               end else begin
                  idx_in = IDX_W'(idx_ff + 1'b1);
               end
            end else if (!clr_stall) begin
               // Clear-all: report the held release, hold this one while under the limit, clear the slot.
               rsp_last_in                 = 1'b0;
               rsp_data_in.slot_out        = pend_slot_ff;
               rsp_data_in.released_handle = pend_hdl_ff;
               emit                        = clr_need_emit;
               idx_in                      = IDX_W'(idx_ff + 1'b1);
               if (hit) begin
                  mem_wr.hdl_we = 1'b1;
                  mem_wr.cnt_we = 1'b1;
                  if (!rep_full) begin
                     pend_slot_in = idx_ext[5:0];
                     pend_hdl_in  = rd.hdl;
                     rep_cnt_in   = rep_cnt_ff + 1'b1;
                  end
               end
            end
         end
         rht_pkg::S_FLUSH: begin
            // The held release is the final one; with none held this is the empty result.
            emit                        = out_free;
            rsp_data_in.slot_out        = pend_slot_ff;
            rsp_data_in.released_handle = pend_hdl_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rht_pkg::S_INIT;
         idx_ff       <= '0;
         rep_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rep_cnt_ff   <= rep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      hnd_ff       <= hnd_in;
      mode_ff      <= mode_in;
      pend_slot_ff <= pend_slot_in;
      pend_hdl_ff  <= pend_hdl_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a word still waiting");

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rht_pkg::S_INIT) |-> (!rsp_valid_ff && !req_tready))
      else $error("traffic during the clearing pass");

   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= rht_pkg::REP_W'(rht_pkg::RESULT_LIMIT))
      else $error("clear-all release count beyond its limit");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      (mem_wr.hdl_we || mem_wr.cnt_we) |-> (state_ff == rht_pkg::S_INIT
         || state_ff == rht_pkg::S_EXEC || state_ff == rht_pkg::S_SCAN_CHK))
      else $error("table written outside a writing state");

   // A slot check may wait on the response side, so only the first check cycle is tied
   // to the read that feeds it.
   a_exec_follows_read: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rht_pkg::S_SCAN_CHK) && ($past(state_ff) != rht_pkg::S_SCAN_CHK))
         |-> $past(rd_en))
      else $error("slot checked without a preceding read");
`endif

endmodule

/* dv/refcounted_handle_table_core_checker.sv */
`timescale 1ns / 1ps

module refcounted_handle_table_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // opcode, slot, object_handle, access_mode, zero pad
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, slot_out, handle_out, mode_out, count_out, released_handle, zero pad
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          words_due,
   output int          words_seen
);

   localparam int SLOTS = rht_pkg::SLOT_COUNT_DEF;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [31:0] hdl;
      logic [3:0]  mode;
      logic [15:0] cnt;
      logic [31:0] released;
      logic        last;
   } slot_result_type;

   // Shadow copy of the slot table.
   logic [31:0]     table_hdl [SLOTS];
   logic [3:0]      table_mode [SLOTS];
   logic [15:0]     table_cnt [SLOTS];
   slot_result_type results_due [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Applies one request word to the shadow table and queues the response words it causes.
   function automatic void apply_request(input rht_pkg::rht_req_type w);
      slot_result_type r;
      slot_result_type prev;
      logic            have_prev;
      logic            found;
      logic [15:0]     c;
      int              i;
      int              n;
      r = '0;
      r.slot = w.slot;
      r.last = 1'b1;
      unique case (w.opcode)
         rht_pkg::OP_ALLOC: begin
            r.slot = '0;
            if (w.object_handle == '0) begin
               r.status = rht_pkg::STS_BAD;
            end else begin
               found = 1'b0;
               for (i = 0; i < SLOTS; i++) begin
                  if (!found && table_hdl[i] == '0) begin
                     found = 1'b1;
                     table_hdl[i] = w.object_handle;
                     table_mode[i] = w.access_mode;
                     table_cnt[i] = 16'd1;
                     r.slot = i[5:0];
                     r.hdl = w.object_handle;
                     r.mode = w.access_mode;
                     r.cnt = 16'd1;
                  end
               end
               r.status = found ? rht_pkg::STS_OK : rht_pkg::STS_FULL;
            end
            results_due.push_back(r);
         end
         rht_pkg::OP_FREE, rht_pkg::OP_PUT: begin
            if (table_hdl[w.slot] == '0) begin
               r.status = rht_pkg::STS_BAD;
            end else begin
               c = (table_cnt[w.slot] == '0) ? '0 : table_cnt[w.slot] - 16'd1;
               table_cnt[w.slot] = c;
               if (c == '0) begin
                  r.released = table_hdl[w.slot];
                  table_hdl[w.slot] = '0;
               end
               r.status = rht_pkg::STS_OK;
               r.cnt = c;
            end
            results_due.push_back(r);
         end
         rht_pkg::OP_GET: begin
            if (table_hdl[w.slot] == '0) begin
               r.status = rht_pkg::STS_BAD;
            end else begin
               if (table_cnt[w.slot] >= rht_pkg::COUNT_MAX) begin
                  r.status = rht_pkg::STS_SAT;
               end else begin
                  r.status = rht_pkg::STS_OK;
                  table_cnt[w.slot] = table_cnt[w.slot] + 16'd1;
               end
               r.hdl = table_hdl[w.slot];
               r.mode = table_mode[w.slot];
               r.cnt = table_cnt[w.slot];
            end
            results_due.push_back(r);
         end
         rht_pkg::OP_CLEAR: begin
            // Hold each release back one step so the final one can carry last.
            have_prev = 1'b0;
            prev = '0;
            n = 0;
            for (i = 0; i < SLOTS; i++) begin
               if (table_hdl[i] != '0) begin
                  if (n < rht_pkg::RESULT_LIMIT) begin
                     if (have_prev) begin
                        results_due.push_back(prev);
                     end
                     prev = '0;
                     prev.status = rht_pkg::STS_OK;
                     prev.slot = i[5:0];
                     prev.released = table_hdl[i];
                     have_prev = 1'b1;
                     n++;
                  end
                  table_hdl[i] = '0;
                  table_cnt[i] = '0;
               end
            end
            if (have_prev) begin
               prev.last = 1'b1;
               results_due.push_back(prev);
            end else begin
               r.slot = '0;
               r.status = rht_pkg::STS_OK;
               results_due.push_back(r);
            end
         end
         default: begin
            r.status = rht_pkg::STS_BAD;
            results_due.push_back(r);
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      rht_pkg::rht_rsp_type got;
      slot_result_type      want;
      int                   i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) begin
            table_hdl[i] = '0;
            table_mode[i] = '0;
            table_cnt[i] = '0;
         end
         results_due.delete();
         mismatch_count = 0;
         words_seen = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(rht_pkg::rht_req_type'(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rht_pkg::rht_rsp_type'(rsp_tdata);
            words_seen++;
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("response word with nothing expected: %h", rsp_tdata));
            end else begin
               want = results_due.pop_front();
               if (got.status != want.status)
                  report_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, got.status));
               if (got.slot_out != want.slot)
                  report_mismatch($sformatf("slot_out: expected %0d, got %0d",
                                            want.slot, got.slot_out));
               if (got.handle_out != want.hdl)
                  report_mismatch($sformatf("handle_out: expected %h, got %h",
                                            want.hdl, got.handle_out));
               if (got.mode_out != want.mode)
                  report_mismatch($sformatf("mode_out: expected %h, got %h",
                                            want.mode, got.mode_out));
               if (got.count_out != want.cnt)
                  report_mismatch($sformatf("count_out: expected %0d, got %0d",
                                            want.cnt, got.count_out));
               if (got.released_handle != want.released)
                  report_mismatch($sformatf("released_handle: expected %h, got %h",
                                            want.released, got.released_handle));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("rsp_tlast: expected %0d, got %0d",
                                            want.last, rsp_tlast));
            end
         end
      end
      words_due <= results_due.size();
   end

endmodule

/* dv/refcounted_handle_table_core_tb.sv */
`timescale 1ns / 1ps

module refcounted_handle_table_core_tb;

   // A quiet stretch is bounded by a full-table alloc or a clear-all walk plus the longest
   // sender gap; the limit allows for that many times over.
   localparam int QUIET_LIMIT = 2000;
   // After the last response word, wait out one clear-all walk in case a stray word follows.
   localparam int TAIL_CYCLES = 2 * rht_pkg::SLOT_COUNT_DEF + 40;
   localparam int RANDOM_BLOCKS = 5;
   localparam int BLOCK_WORDS   = 20;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // opcode[2:0], slot[8:3], object_handle[40:9], access_mode[44:41], zero pad[47:45]
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // status[1:0], slot_out[7:2], handle_out[39:8], mode_out[43:40], count_out[59:44],
   // released_handle[91:60], zero pad[95:92]
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   int   mismatch_count;
   int   words_due;
   int   words_seen;
   int   words_sent = 0;
   int   quiet_cycles = 0;
   int   rsp_hold = 0;
   // When set, both sides insert random idle cycles between words.
   logic idle_on = 1'b1;

   // 100 MHz clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   refcounted_handle_table_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   refcounted_handle_table_core_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_due      (words_due),
      .words_seen     (words_seen)
   );

   // Response side: after each accepted word, ready may drop for a random stall. The stall is
   // drawn per word, so it lands on every phase of a clear-all walk as well as on single
   // results. With idling off, ready simply stays high.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         rsp_hold <= stall;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
         end
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_hold <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // The watchdog counts cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("Timed out after %0d cycles without a handshake.", QUIET_LIMIT);
      $display("refcounted_handle_table_core regression: fail");
      $finish;
   end

   // Presents one request word and returns at the edge that accepts it. Valid stays high
   // into the next word when no gap is drawn, so it never falls and rises in one step.
   task automatic send_word(input logic [2:0] op, input logic [5:0] slot,
                            input logic [31:0] hdl, input logic [3:0] mode);
      int                   gap;
      rht_pkg::rht_req_type w;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      w = '0;
      w.opcode = op;
      w.slot = slot;
      w.object_handle = hdl;
      w.access_mode = mode;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do begin
         @(posedge clock);
      end while (!req_tready);
      words_sent++;
   endtask

   // A random word, weighted so that most operations hit open slots: alloc fills the table
   // from the bottom, so the low slots are the ones usually open.
   task automatic send_random_word();
      int          pick;
      logic [2:0]  op;
      logic [5:0]  slot;
      logic [31:0] hdl;
      pick = $urandom_range(0, 99);
      if (pick < 35) op = rht_pkg::OP_ALLOC;
      else if (pick < 55) op = rht_pkg::OP_GET;
      else if (pick < 70) op = rht_pkg::OP_FREE;
      else if (pick < 88) op = rht_pkg::OP_PUT;
      else if (pick < 92) op = rht_pkg::OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      slot = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
      hdl = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
      send_word(op, slot, hdl, 4'($urandom_range(0, 15)));
   endtask

   initial begin : stimulus
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extremes of handle and mode, every operation, closed
      // and out-of-use slots, and unknown opcodes.
      send_word(rht_pkg::OP_CLEAR, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_ALLOC, 6'd63, 32'd0, 4'hF);
      send_word(rht_pkg::OP_ALLOC, 6'd0, 32'hFFFF_FFFF, 4'hF);
      send_word(rht_pkg::OP_ALLOC, 6'd63, 32'h0000_0001, 4'h0);
      send_word(rht_pkg::OP_GET, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_PUT, 6'd0, 32'hFFFF_FFFF, 4'hF);
      send_word(rht_pkg::OP_FREE, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_GET, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_FREE, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_PUT, 6'd63, 32'd0, 4'h0);
      send_word(rht_pkg::OP_GET, 6'd63, 32'd0, 4'h0);
      send_word(3'd5, 6'd63, 32'hFFFF_FFFF, 4'hF);
      send_word(3'd6, 6'd1, 32'd0, 4'h0);
      send_word(3'd7, 6'd0, 32'hA5A5_5A5A, 4'h5);
      send_word(rht_pkg::OP_GET, 6'd1, 32'd0, 4'h0);

      // Fill the table to the top and ask beyond it to see the full status, then touch the
      // highest slot and release everything with one clear-all.
      for (i = 0; i < rht_pkg::SLOT_COUNT_DEF + 1; i++) begin
         send_word(rht_pkg::OP_ALLOC, 6'd0, $urandom | 32'd1, 4'($urandom_range(0, 15)));
      end
      send_word(rht_pkg::OP_GET, 6'd63, 32'd0, 4'h0);
      send_word(rht_pkg::OP_PUT, 6'd63, 32'd0, 4'h0);
      send_word(rht_pkg::OP_PUT, 6'd63, 32'd0, 4'h0);
      send_word(rht_pkg::OP_FREE, 6'd63, 32'd0, 4'h0);
      send_word(rht_pkg::OP_CLEAR, 6'd0, 32'd0, 4'h0);

      // Step one reference count up and down with no idling, then release it with clear-all.
      idle_on = 1'b0;
      send_word(rht_pkg::OP_ALLOC, 6'd0, 32'h5A5A_0001, 4'hA);
      repeat (3) send_word(rht_pkg::OP_GET, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_PUT, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_GET, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_FREE, 6'd0, 32'd0, 4'h0);
      send_word(rht_pkg::OP_CLEAR, 6'd0, 32'd0, 4'h0);

      // Random part in blocks; about one block in four runs without any idling.
      for (i = 0; i < RANDOM_BLOCKS; i++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (BLOCK_WORDS) send_random_word();
      end
      req_tvalid <= 1'b0;

      // Wait for every expected response word, then for a clear-all walk more.
      @(posedge clock);
      while (words_due != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d request words and checked %0d response words.", words_sent, words_seen);
      $display("Covered empty and full table, zero handles, closed slots, unknown opcodes,");
      $display("reference counts stepped up and down, and clear-all with and without open slots.");
      if (mismatch_count == 0) begin
         $display("refcounted_handle_table_core regression: pass");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("refcounted_handle_table_core regression: fail");
      end
      $finish;
   end

endmodule
